### src/sircu_pkg.sv
// ----------------------------------------------------------------------------
// SIR contact update engine package
// Shared types, code constants and helpers for the node-state update engine.
// ----------------------------------------------------------------------------
package sircu_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int NODE_W       = 12;
    localparam int COUNT_W      = 13;
    localparam int RAND_W       = 16;
    localparam int NODE_COUNT_DEFAULT = 4096;

    localparam logic [1:0] ST_S = 2'd0;
    localparam logic [1:0] ST_I = 2'd1;
    localparam logic [1:0] ST_R = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    localparam logic [2:0] OUT_UNCHANGED = 3'd0;
    localparam logic [2:0] OUT_INFECTED  = 3'd1;
    localparam logic [2:0] OUT_RECOVERED = 3'd2;
    localparam logic [2:0] OUT_REDRAW    = 3'd3;
    localparam logic [2:0] OUT_LOADED    = 3'd4;

    localparam logic CFG_INFECT  = 1'b0;
    localparam logic CFG_RECOVER = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] chosen_node;
        logic [NODE_W-1:0] partner_node;
        logic [1:0]        load_state;
        logic [RAND_W-1:0] random_value;
    } sircu_req_t;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [1:0]         node_state_after;
        logic [COUNT_W-1:0] count_susceptible;
        logic [COUNT_W-1:0] count_infected;
        logic [COUNT_W-1:0] count_recovered;
    } sircu_rsp_t;

    typedef struct packed {
        logic       write;
        logic       change;
        logic [1:0] new_state;
        logic [2:0] outcome;
        logic [1:0] after;
    } sircu_upd_t;

    function automatic int active_nodes(input int node_count);
        return (node_count > STORE_DEPTH) ? STORE_DEPTH : node_count;
    endfunction

endpackage

### src/sir_contact_update_engine_core.sv
// ----------------------------------------------------------------------------
// SIR contact update engine
// Stochastic SIR contact and recovery updates over a node-state memory.
// ----------------------------------------------------------------------------
// Usage: an item is transferred at a clock edge where start is high and busy
// is low. A load item writes one node's state; an event item tests a chosen
// node against its partner and a random draw. Exactly one result follows
// each item: done is registered from the update state after the transfer
// and stays high for one cycle, with rsp holding the outcome, the node's
// new state and the S/I/R counts. Each item is handled in order: the
// chosen and partner entries are read from the node memory, then the
// update state decides and writes back; busy stays high through it, so no
// new item is taken before the last one is through. Results cannot be
// stalled; the receiver must take each when done is high. The thresholds
// are written on the cfg channel, which is always ready, and should only
// be changed while the block is idle. After reset the block clears the
// active node entries to susceptible, one per cycle, holding busy high
// until the last one is cleared, before the first item can be transferred.
// ----------------------------------------------------------------------------
module sir_contact_update_engine_core #(
    parameter int NODE_COUNT = sircu_pkg::NODE_COUNT_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  sircu_pkg::sircu_req_t   req,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data,
    output logic                    done,
    output sircu_pkg::sircu_rsp_t   rsp
);
    import sircu_pkg::*;

    localparam int                 ACTIVE    = active_nodes(NODE_COUNT);
    localparam logic [COUNT_W-1:0] ACTIVE_W  = COUNT_W'(ACTIVE);
    localparam logic [NODE_W-1:0]  CLEAR_END = NODE_W'(ACTIVE - 1);

    localparam logic [1:0] FSM_CLEAR = 2'd0;
    localparam logic [1:0] FSM_IDLE  = 2'd1;
    localparam logic [1:0] FSM_EXEC  = 2'd2;

    logic [1:0]         fsm_reg, fsm_next;
    logic [NODE_W-1:0]  clr_reg, clr_next;
    logic [15:0]        infect_reg, recover_reg;
    sircu_req_t         item_reg;
    sircu_rsp_t         rsp_reg;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] cnt_s_reg, cnt_i_reg, cnt_r_reg;
    logic [COUNT_W-1:0] cnt_s_next, cnt_i_next, cnt_r_next;

    logic               accept;
    logic [1:0]         cur_state, partner_state;
    sircu_upd_t         upd;
    logic               wr_en;
    logic [NODE_W-1:0]  wr_addr;
    logic [1:0]         wr_data;

    assign accept    = start && !busy;
    assign busy      = (fsm_reg != FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    sircu_node_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr_a (req.chosen_node),
        .rd_addr_b (req.partner_node),
        .rd_data_a (cur_state),
        .rd_data_b (partner_state),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    sircu_update #(
        .NODE_COUNT (NODE_COUNT)
    ) u_update (
        .item              (item_reg),
        .cur_state         (cur_state),
        .partner_state     (partner_state),
        .infect_threshold  (infect_reg),
        .recover_threshold (recover_reg),
        .upd               (upd)
    );

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = item_reg.chosen_node;
        wr_data = upd.new_state;
        if (fsm_reg == FSM_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = ST_S;
        end
        else if (fsm_reg == FSM_EXEC)
        begin
            wr_en = upd.write;
        end
    end

    always_comb
    begin
        fsm_next  = fsm_reg;
        clr_next  = clr_reg;
        done_next = 1'b0;
        unique case (fsm_reg)
            FSM_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLEAR_END)
                begin
                    fsm_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (accept)
                begin
                    fsm_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                fsm_next  = FSM_IDLE;
                done_next = 1'b1;
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_s_next = cnt_s_reg;
        cnt_i_next = cnt_i_reg;
        cnt_r_next = cnt_r_reg;
        if (fsm_reg == FSM_EXEC && upd.change)
        begin
            unique case (cur_state)
                ST_S:    cnt_s_next = cnt_s_reg - 1'b1;
                ST_I:    cnt_i_next = cnt_i_reg - 1'b1;
                default: cnt_r_next = cnt_r_reg - 1'b1;
            endcase
            unique case (upd.new_state)
                ST_S:    cnt_s_next = cnt_s_next + 1'b1;
                ST_I:    cnt_i_next = cnt_i_next + 1'b1;
                default: cnt_r_next = cnt_r_next + 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg     <= FSM_CLEAR;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
            cnt_s_reg   <= ACTIVE_W;
            cnt_i_reg   <= '0;
            cnt_r_reg   <= '0;
            infect_reg  <= 16'd8192;
            recover_reg <= 16'd3277;
        end
        else
        begin
            fsm_reg   <= fsm_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            cnt_s_reg <= cnt_s_next;
            cnt_i_reg <= cnt_i_next;
            cnt_r_reg <= cnt_r_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_INFECT:  infect_reg  <= cfg_data;
                    CFG_RECOVER: recover_reg <= cfg_data;
                    default:     infect_reg  <= infect_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (fsm_reg == FSM_EXEC)
        begin
            rsp_reg.outcome           <= upd.outcome;
            rsp_reg.node_state_after  <= upd.after;
            rsp_reg.count_susceptible <= cnt_s_next;
            rsp_reg.count_infected    <= cnt_i_next;
            rsp_reg.count_recovered   <= cnt_r_next;
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("A transferred item did not produce a result two cycles later.");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (COUNT_W'(cnt_s_reg + cnt_i_reg + cnt_r_reg) == ACTIVE_W))
        else $error("The S/I/R counts no longer add up to the active node count.");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(fsm_reg == FSM_EXEC))
        else $error("A result strobe appeared without an update cycle before it.");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.node_state_after <= ST_R))
        else $error("A result reported an invalid node state.");

endmodule

### src/sircu_node_store.sv
// ----------------------------------------------------------------------------
// SIR node store
// Node-state memory with two registered read ports and one write port.
// ----------------------------------------------------------------------------
module sircu_node_store #(
    parameter int DEPTH = sircu_pkg::STORE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
    output logic [1:0]                 rd_data_a,
    output logic [1:0]                 rd_data_b,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [1:0]                 wr_data
);
    import sircu_pkg::*;

    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### src/sircu_update.sv
// ----------------------------------------------------------------------------
// SIR update decision
// Decides the new node state and the outcome code for one load or event.
// ----------------------------------------------------------------------------
module sircu_update #(
    parameter int NODE_COUNT = sircu_pkg::NODE_COUNT_DEFAULT
) (
    input  sircu_pkg::sircu_req_t   item,
    input  logic [1:0]              cur_state,
    input  logic [1:0]              partner_state,
    input  logic [15:0]             infect_threshold,
    input  logic [15:0]             recover_threshold,
    output sircu_pkg::sircu_upd_t   upd
);
    import sircu_pkg::*;

    localparam logic [COUNT_W-1:0] ACTIVE_W = COUNT_W'(active_nodes(NODE_COUNT));

    logic       chosen_ok;
    logic       partner_ok;
    logic       go;
    logic [1:0] target;
    logic [2:0] code;

    assign chosen_ok  = {1'b0, item.chosen_node} < ACTIVE_W;
    assign partner_ok = {1'b0, item.partner_node} < ACTIVE_W;

    always_comb
    begin
        go     = 1'b0;
        target = cur_state;
        code   = OUT_UNCHANGED;
        if (item.req_type == REQ_LOAD)
        begin
            if (item.load_state <= ST_R)
            begin
                go     = 1'b1;
                target = item.load_state;
                code   = OUT_LOADED;
            end
        end
        else if (cur_state == ST_S)
        begin
            if (item.partner_node == item.chosen_node)
            begin
                code = OUT_REDRAW;
            end
            else if (partner_ok && partner_state == ST_I
                     && item.random_value <= infect_threshold)
            begin
                go     = 1'b1;
                target = ST_I;
                code   = OUT_INFECTED;
            end
        end
        else if (cur_state == ST_I)
        begin
            if (item.random_value <= recover_threshold)
            begin
                go     = 1'b1;
                target = ST_R;
                code   = OUT_RECOVERED;
            end
        end

        upd.write     = chosen_ok && go;
        upd.change    = chosen_ok && go && (target != cur_state);
        upd.new_state = target;
        upd.outcome   = chosen_ok ? code : OUT_UNCHANGED;
        upd.after     = chosen_ok ? target : ST_S;
    end

endmodule
